/* design/mccn_pkg.sv */
// Shared types and constants of the matrix column normaliser.
package mccn_pkg;

    // Default sizes handed to the top level.
    localparam int ROWS_DEF        = 16;
    localparam int SAMPLE_BITS_DEF = 11;

    // Fixed field widths.
    localparam int THR_W    = 11;
    localparam int REF_W    = 16;
    localparam int SUM_W    = 15;
    localparam int TAG_W    = 4;
    localparam int VALUE_W  = 8;

    // Column sum saturates here.
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Full-scale output value, 2**SCALE_SH - 1.
    localparam int                 SCALE_SH = 8;
    localparam logic [VALUE_W-1:0] SCALE    = {VALUE_W{1'b1}};

    // Quotient bits produced by the divider: the value bits plus one overflow bit.
    localparam int QUOT_BITS = VALUE_W + 1;

    // Register reset values.
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);
    localparam logic [REF_W-1:0] REF_RESET = REF_W'(4096);

    // Configuration port geometry.
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_LSB   = 2;
    localparam int REG_IDX_W = 1;

    // Register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESHOLD = 1'b0,
        REG_REFERENCE = 1'b1
    } t_reg_idx;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [REF_W-1:0] ref_level;
    } t_cfg;

endpackage

/* design/mccn_apb_regs.sv */
// Configuration registers behind the APB-style port.
module mccn_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mccn_pkg::ADDR_W-1:0] paddr,
    input  logic [mccn_pkg::DATA_W-1:0] pwdata,
    output logic [mccn_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output mccn_pkg::t_cfg              o_cfg
);

    mccn_pkg::t_cfg   r_cfg;
    mccn_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = mccn_pkg::t_reg_idx'(paddr[mccn_pkg::REG_LSB +: mccn_pkg::REG_IDX_W]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= mccn_pkg::THR_RESET;
            r_cfg.ref_level <= mccn_pkg::REF_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                mccn_pkg::REG_THRESHOLD:
                    r_cfg.threshold <= pwdata[mccn_pkg::THR_W-1:0];
                mccn_pkg::REG_REFERENCE:
                    r_cfg.ref_level <= pwdata[mccn_pkg::REF_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        unique case (w_idx)
            mccn_pkg::REG_THRESHOLD: prdata = mccn_pkg::DATA_W'(r_cfg.threshold);
            mccn_pkg::REG_REFERENCE: prdata = mccn_pkg::DATA_W'(r_cfg.ref_level);
            default:                 prdata = '0;
        endcase
    end

endmodule

/* design/mccn_col_store.sv */
// Per-row sample memory and the saturating running column sum.
module mccn_col_store #(
    parameter int ROWS        = mccn_pkg::ROWS_DEF,
    parameter int SAMPLE_BITS = mccn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [$clog2(ROWS)-1:0]    i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]     i_wr_data,
    input  logic [$clog2(ROWS)-1:0]    i_rd_addr,
    output logic [SAMPLE_BITS-1:0]     o_rd_data,
    input  logic                       i_sum_clr,
    output logic [mccn_pkg::SUM_W-1:0] o_sum
);

    localparam int ACC_W =
        ((mccn_pkg::SUM_W > SAMPLE_BITS) ? mccn_pkg::SUM_W : SAMPLE_BITS) + 1;

    logic [SAMPLE_BITS-1:0]     r_mem [ROWS];
    logic [SAMPLE_BITS-1:0]     r_rd_data;
    logic [mccn_pkg::SUM_W-1:0] r_sum;
    logic [ACC_W-1:0]           w_acc;

    // The memory has one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

    // The sum adds every sample written to the memory and clamps at its full-scale value.
    assign w_acc = ACC_W'(r_sum) + ACC_W'(i_wr_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_sum_clr) begin
            r_sum <= '0;
        end else if (i_wr_en) begin
            if (w_acc > ACC_W'(mccn_pkg::SUM_MAX)) begin
                r_sum <= mccn_pkg::SUM_MAX;
            end else begin
                r_sum <= w_acc[mccn_pkg::SUM_W-1:0];
            end
        end
    end

    assign o_sum = r_sum;

endmodule

/* design/mccn_divider.sv */
// Restoring divider, one quotient bit per cycle, most significant bit first.
// The first bit carries weight 256 and flags a quotient that does not fit.
module mccn_divider #(
    parameter int NUM_W = mccn_pkg::SAMPLE_BITS_DEF + mccn_pkg::SCALE_SH,
    parameter int DVS_W = mccn_pkg::REF_W + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [DVS_W-1:0]             i_den,
    output logic                         o_done,
    output logic [mccn_pkg::VALUE_W-1:0] o_quot,
    output logic                         o_over
);

    localparam int QB     = mccn_pkg::QUOT_BITS;
    localparam int DIV_W  = DVS_W + QB - 1;
    localparam int CMP_W  = ((NUM_W > DIV_W) ? NUM_W : DIV_W) + 1;
    localparam int STEP_W = $clog2(QB);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [QB-1:0]     r_quot;
    logic [CMP_W-1:0]  w_diff;
    logic              w_fit;

    // Trial subtraction of the shifted divisor.
    assign w_diff = CMP_W'(r_rem) - CMP_W'(r_div);
    assign w_fit  = !w_diff[CMP_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(QB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and quotient registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_div  <= DIV_W'(i_den) << (QB - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= NUM_W'(w_diff);
            end
            r_div  <= r_div >> 1;
            r_quot <= {r_quot[QB-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot[mccn_pkg::VALUE_W-1:0];
    assign o_over = r_quot[QB-1];

endmodule

/* design/matrix_column_crosstalk_normalizer_unit.sv */
// Column normaliser for a resistive sensor matrix. Samples are taken one item per
// cycle while the block is idle; each is stored under its row and added into a
// saturating column sum. The item marked column_end starts the output pass: for
// every row in order the stored value v gives 0 when at or below the threshold,
// otherwise 255*v / (reference - (sum - v)), clipped to 255 with the saturated
// flag when the quotient exceeds 255 or the denominator is not positive. All
// rows share one bit-serial divider, so a row that divides passes through memory
// read, operand set-up, 9 divide steps, the hand-over of the quotient and output,
// and a row that does not passes through memory read, operand set-up and output,
// plus any wait for the output to be taken. No input item is accepted during the
// output pass. The sample store is not cleared at reset: a row not written since
// reset yields an undefined result.
module matrix_column_crosstalk_normalizer_unit #(
    parameter int ROWS        = mccn_pkg::ROWS_DEF,
    parameter int SAMPLE_BITS = mccn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mccn_pkg::ADDR_W-1:0]   paddr,
    input  logic [mccn_pkg::DATA_W-1:0]   pwdata,
    output logic [mccn_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic [mccn_pkg::TAG_W-1:0]    i_row_index,
    input  logic [mccn_pkg::TAG_W-1:0]    i_column_index,
    input  logic                          i_column_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mccn_pkg::TAG_W-1:0]    o_out_row,
    output logic [mccn_pkg::TAG_W-1:0]    o_out_column,
    output logic [mccn_pkg::VALUE_W-1:0]  o_scaled_value,
    output logic                          o_saturated,
    output logic                          o_last_row
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int IDX_W = ((ROW_W > mccn_pkg::TAG_W) ? ROW_W : mccn_pkg::TAG_W) + 1;
    localparam int NUM_W = SAMPLE_BITS + mccn_pkg::SCALE_SH;
    localparam int DEN_W =
        ((mccn_pkg::REF_W > SAMPLE_BITS) ? mccn_pkg::REF_W : SAMPLE_BITS) + 2;
    localparam int THC_W =
        (mccn_pkg::THR_W > SAMPLE_BITS) ? mccn_pkg::THR_W : SAMPLE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_OUT
    } t_state;

    t_state                       r_state;
    logic [ROW_W-1:0]             r_cnt;
    logic [mccn_pkg::TAG_W-1:0]   r_col;
    logic                         r_out_valid;
    logic [mccn_pkg::VALUE_W-1:0] r_value;
    logic                         r_sat;

    mccn_pkg::t_cfg               w_cfg;
    logic                         w_in_acc;
    logic                         w_out_acc;
    logic                         w_row_ok;
    logic                         w_last;
    logic [SAMPLE_BITS-1:0]       w_v;
    logic [mccn_pkg::SUM_W-1:0]   w_sum;
    logic                         w_quiet;
    logic [DEN_W-1:0]             w_den;
    logic                         w_den_np;
    logic [NUM_W-1:0]             w_num;
    logic                         w_div_start;
    logic                         w_div_done;
    logic [mccn_pkg::VALUE_W-1:0] w_quot;
    logic                         w_over;

    // Configuration registers.
    mccn_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshakes; a row outside the matrix is neither stored nor summed.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_acc  = r_out_valid && i_out_ready;
    assign w_row_ok   = IDX_W'(i_row_index) < IDX_W'(ROWS);
    assign w_last     = (r_cnt == ROW_W'(ROWS - 1));

    mccn_col_store #(
        .ROWS        (ROWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_in_acc && w_row_ok),
        .i_wr_addr (ROW_W'(i_row_index)),
        .i_wr_data (i_sample),
        .i_rd_addr (r_cnt),
        .o_rd_data (w_v),
        .i_sum_clr (w_out_acc && w_last),
        .o_sum     (w_sum)
    );

    // Operand set-up: threshold test, signed denominator and 255 times the value.
    assign w_quiet  = THC_W'(w_v) <= THC_W'(w_cfg.threshold);
    assign w_den    = DEN_W'(w_cfg.ref_level) - DEN_W'(w_sum) + DEN_W'(w_v);
    assign w_den_np = w_den[DEN_W-1] || (w_den == '0);
    assign w_num    = (NUM_W'(w_v) << mccn_pkg::SCALE_SH) - NUM_W'(w_v);

    assign w_div_start = (r_state == S_LOAD) && !w_quiet && !w_den_np;

    mccn_divider #(
        .NUM_W (NUM_W),
        .DVS_W (DEN_W - 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den[DEN_W-2:0]),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_over  (w_over)
    );

    // Sequencer over the rows of a column, with the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_value     <= '0;
            r_sat       <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_col <= i_column_index;
                        if (i_column_end) begin
                            r_cnt   <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_quiet) begin
                        r_value     <= '0;
                        r_sat       <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else if (w_den_np) begin
                        r_value     <= mccn_pkg::SCALE;
                        r_sat       <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_value     <= w_over ? mccn_pkg::SCALE : w_quot;
                        r_sat       <= w_over;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_acc) begin
                        r_out_valid <= 1'b0;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + ROW_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_row      = mccn_pkg::TAG_W'(r_cnt);
    assign o_out_column   = r_col;
    assign o_scaled_value = r_value;
    assign o_saturated    = r_sat;
    assign o_last_row     = w_last;

endmodule

/* design/mccn_checker.sv */
// Port-level checks of the column normaliser.
module mccn_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         i_column_end,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [mccn_pkg::VALUE_W-1:0] o_scaled_value,
    input logic                         o_saturated,
    input logic                         o_last_row
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_scaled_value))
        else $error("result changed while stalled");

    // No item is taken while a column is being emitted.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready during output pass");

    // The final item of a column starts the output pass.
    a_end_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_column_end |=> !o_in_ready)
        else $error("column end did not start the output pass");

    // Taking the last row returns the block to accepting items.
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_row |=> o_in_ready && !o_out_valid)
        else $error("block not idle after the last row");

    // A saturated result is always full scale.
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> o_scaled_value == mccn_pkg::SCALE)
        else $error("saturated result below full scale");

endmodule

bind matrix_column_crosstalk_normalizer_unit mccn_checker u_mccn_checker (.*);
